FILE: rtl/grdr_pkg.sv
// Shared types and constants for the glyph renderer.
// Action codes, register indexes, reset values, limits and masks; no dependencies.
`default_nettype none

package grdr_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_LOAD  = 2'd0;
	localparam action_t ACT_PUT   = 2'd1;
	localparam action_t ACT_FLUSH = 2'd2;

	typedef logic [1:0] reg_idx_t;

	localparam reg_idx_t REG_GLYPH_WIDTH     = 2'd0;
	localparam reg_idx_t REG_GLYPH_HEIGHT    = 2'd1;
	localparam reg_idx_t REG_BYTES_PER_GLYPH = 2'd2;
	localparam reg_idx_t REG_TEXT_MODE       = 2'd3;

	localparam int CFG_DATA_W = 6;

	localparam logic [4:0] RST_GLYPH_WIDTH     = 5'd8;
	localparam logic [4:0] RST_GLYPH_HEIGHT    = 5'd8;
	localparam logic [5:0] RST_BYTES_PER_GLYPH = 6'd8;
	localparam logic       RST_TEXT_MODE       = 1'b0;

	localparam logic [4:0] MAX_GLYPH_DIM = 5'd16;
	localparam logic [4:0] BITS_PER_BYTE = 5'd8;
	localparam logic [7:0] INV_MASK      = 8'hFF;
	localparam logic [7:0] SHADE_EVEN    = 8'hAA;
	localparam logic [7:0] SHADE_ODD     = 8'h55;
	localparam logic [9:0] RECT_MAX      = 10'd1023;

endpackage

`default_nettype wire

FILE: rtl/glyph_renderer_with_dirty_rect_top.sv
// Top level of the glyph renderer with dirty rectangle tracking.
// Uses grdr_pkg and the font store RAM grdr_ram.
//
// After reset the font store is swept to zero, one entry a cycle; in_stall
// stays high meanwhile while configuration writes are taken. A load writes
// the font store as it is taken, and a flush waits out any output stall. A
// put first runs a six-step restoring divider for bytes per glyph row, then
// reads the font store one byte at a time through its single read port,
// fetching and capturing one byte per glyph row for widths up to 8 and two
// above, then emitting the row once the output slot is free. The block works
// on one item at a time; the result register lets the last row wait while the
// next item enters.
`default_nettype none

module glyph_renderer_with_dirty_rect_top
	import grdr_pkg::*;
#(
	parameter int GLYPH_COUNT     = 128,
	parameter int MAX_GLYPH_BYTES = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            action,
	input  wire logic [6:0]            char_code,
	input  wire logic [4:0]            byte_index,
	input  wire logic [7:0]            font_byte,
	input  wire logic [5:0]            text_col,
	input  wire logic [5:0]            text_row,
	input  wire logic [7:0]            colour,
	input  wire logic                  invert,
	input  wire logic                  shade,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [63:0]                pixel_row,
	output logic [9:0]                 pixel_x,
	output logic [9:0]                 pixel_y,
	output logic                       last,
	output logic [9:0]                 rect_x,
	output logic [9:0]                 rect_y,
	output logic [9:0]                 rect_w,
	output logic [9:0]                 rect_h
);

	localparam int DEPTH  = GLYPH_COUNT * MAX_GLYPH_BYTES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [6:0] MAX_BYTES = 7'(MAX_GLYPH_BYTES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV,
		S_FETCH,
		S_CAPTURE,
		S_EMIT,
		S_MERGE,
		S_FLUSH
	} state_t;

	function automatic logic [63:0] pack_row(logic [15:0] bits, logic [4:0] w,
		logic [3:0] fg, logic [2:0] bg);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < w) begin
				r[63-4*i -: 4] = bits[15-i] ? fg : {1'b0, bg};
			end
		end
		return r;
	endfunction

	state_t state_q;

	logic [4:0] glyph_width_q;
	logic [4:0] glyph_height_q;
	logic [5:0] bytes_per_glyph_q;
	logic       text_mode_q;

	logic [6:0] code_q;
	logic [5:0] col_q;
	logic [5:0] row_cell_q;
	logic [3:0] fg_q;
	logic [2:0] bg_q;
	logic       xor_on_q;
	logic       shade_q;

	logic [4:0] rem_q;
	logic [5:0] dvd_q;
	logic [5:0] quo_q;
	logic [2:0] div_cnt_q;

	logic [5:0] off_q;
	logic [5:0] grem_q;
	logic [5:0] grp_q;
	logic       rd_ok_q;
	logic       mod_ok_q;
	logic       par_q;
	logic       byte_sel_q;
	logic [7:0] byte_hi_q;
	logic [7:0] byte_lo_q;
	logic [3:0] row_q;

	logic [9:0] dirty_x_q;
	logic [9:0] dirty_y_q;
	logic [9:0] dirty_w_q;
	logic [9:0] dirty_h_q;

	logic [ADDR_W-1:0] clr_addr_q;

	logic        out_valid_q;
	logic [63:0] pixel_row_q;
	logic [9:0]  pixel_x_q;
	logic [9:0]  pixel_y_q;
	logic        last_q;
	logic [9:0]  rect_x_q;
	logic [9:0]  rect_y_q;
	logic [9:0]  rect_w_q;
	logic [9:0]  rect_h_q;

	logic [4:0]  w_eff;
	logic [4:0]  h_eff;
	logic [6:0]  bpg_ext;
	logic [6:0]  bpg_eff;
	logic        two_bytes;
	logic [10:0] x0;
	logic [10:0] y0;
	logic [5:0]  trial;
	logic [5:0]  diff;
	logic        take;
	logic        slot_free;
	logic        out_load;
	logic        in_xfer;
	logic [7:0]  rd_byte;
	logic [7:0]  mod_byte;
	logic        row_last;

	logic [10:0] x1;
	logic [10:0] y1;
	logic [11:0] x2;
	logic [11:0] y2;
	logic [11:0] xa;
	logic [11:0] xb;
	logic [11:0] ya;
	logic [11:0] yb;
	logic [11:0] wd;
	logic [11:0] hd;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	always_comb begin
		if (glyph_width_q == 5'd0) begin
			w_eff = 5'd1;
		end else if (glyph_width_q > MAX_GLYPH_DIM) begin
			w_eff = MAX_GLYPH_DIM;
		end else begin
			w_eff = glyph_width_q;
		end
		if (glyph_height_q == 5'd0) begin
			h_eff = 5'd1;
		end else if (glyph_height_q > MAX_GLYPH_DIM) begin
			h_eff = MAX_GLYPH_DIM;
		end else begin
			h_eff = glyph_height_q;
		end
		bpg_ext = {1'b0, bytes_per_glyph_q};
		if (bpg_ext == 7'd0) begin
			bpg_eff = 7'd1;
		end else if (bpg_ext > MAX_BYTES) begin
			bpg_eff = MAX_BYTES;
		end else begin
			bpg_eff = bpg_ext;
		end
	end

	assign two_bytes = (w_eff > BITS_PER_BYTE);
	assign x0        = 11'(w_eff * col_q);
	assign y0        = 11'(h_eff * row_cell_q);
	assign row_last  = ({1'b0, row_q} == 5'(h_eff - 5'd1));

	assign trial = {rem_q, dvd_q[5]};
	assign diff  = trial - {1'b0, h_eff};
	assign take  = (trial >= {1'b0, h_eff});

	assign rd_byte = rd_ok_q ? ram_rdata : 8'd0;
	always_comb begin
		mod_byte = rd_byte;
		if (mod_ok_q) begin
			if (xor_on_q) begin
				mod_byte = mod_byte ^ INV_MASK;
			end
			if (shade_q) begin
				mod_byte = mod_byte | (par_q ? SHADE_ODD : SHADE_EVEN);
			end
		end
	end

	assign x1 = (x0 < {1'b0, dirty_x_q}) ? x0 : {1'b0, dirty_x_q};
	assign y1 = (y0 < {1'b0, dirty_y_q}) ? y0 : {1'b0, dirty_y_q};
	assign xa = {1'b0, x0} + {7'd0, w_eff};
	assign xb = {2'b0, dirty_x_q} + {2'b0, dirty_w_q};
	assign ya = {1'b0, y0} + {7'd0, h_eff};
	assign yb = {2'b0, dirty_y_q} + {2'b0, dirty_h_q};
	assign x2 = (xa > xb) ? xa : xb;
	assign y2 = (ya > yb) ? ya : yb;
	assign wd = x2 - {1'b0, x1};
	assign hd = y2 - {1'b0, y1};

	assign slot_free = !out_valid_q || !out_stall;
	assign out_load  = ((state_q == S_EMIT) || (state_q == S_FLUSH)) && slot_free;
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = 8'd0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (in_xfer && action == ACT_LOAD &&
			32'(char_code) < GLYPH_COUNT && 32'(byte_index) < MAX_GLYPH_BYTES) begin
			ram_we    = 1'b1;
			ram_waddr = ADDR_W'(32'(char_code) * MAX_GLYPH_BYTES + 32'(byte_index));
			ram_wdata = font_byte;
		end
	end

	assign ram_re    = (state_q == S_FETCH);
	assign ram_raddr = ADDR_W'(32'(code_q) * MAX_GLYPH_BYTES + 32'(off_q));

	grdr_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_font_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q     <= RST_GLYPH_WIDTH;
			glyph_height_q    <= RST_GLYPH_HEIGHT;
			bytes_per_glyph_q <= RST_BYTES_PER_GLYPH;
			text_mode_q       <= RST_TEXT_MODE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GLYPH_WIDTH:     glyph_width_q     <= cfg_data[4:0];
				REG_GLYPH_HEIGHT:    glyph_height_q    <= cfg_data[4:0];
				REG_BYTES_PER_GLYPH: bytes_per_glyph_q <= cfg_data[5:0];
				REG_TEXT_MODE:       text_mode_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			code_q      <= '0;
			col_q       <= '0;
			row_cell_q  <= '0;
			fg_q        <= '0;
			bg_q        <= '0;
			xor_on_q    <= 1'b0;
			shade_q     <= 1'b0;
			rem_q       <= '0;
			dvd_q       <= '0;
			quo_q       <= '0;
			div_cnt_q   <= '0;
			off_q       <= '0;
			grem_q      <= '0;
			grp_q       <= '0;
			rd_ok_q     <= 1'b0;
			mod_ok_q    <= 1'b0;
			par_q       <= 1'b0;
			byte_sel_q  <= 1'b0;
			byte_hi_q   <= '0;
			byte_lo_q   <= '0;
			row_q       <= '0;
			dirty_x_q   <= '0;
			dirty_y_q   <= '0;
			dirty_w_q   <= '0;
			dirty_h_q   <= '0;
			out_valid_q <= 1'b0;
			pixel_row_q <= '0;
			pixel_x_q   <= '0;
			pixel_y_q   <= '0;
			last_q      <= 1'b0;
			rect_x_q    <= '0;
			rect_y_q    <= '0;
			rect_w_q    <= '0;
			rect_h_q    <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						code_q     <= char_code;
						col_q      <= text_col;
						row_cell_q <= text_row;
						fg_q       <= colour[3:0];
						bg_q       <= colour[6:4];
						xor_on_q   <= invert || (colour[7] && !text_mode_q);
						shade_q    <= shade;
						rem_q      <= '0;
						dvd_q      <= bpg_eff[5:0];
						quo_q      <= '0;
						div_cnt_q  <= '0;
						off_q      <= '0;
						grem_q     <= '0;
						grp_q      <= '0;
						byte_sel_q <= 1'b0;
						byte_lo_q  <= '0;
						row_q      <= '0;
						if (action == ACT_PUT) begin
							state_q <= S_DIV;
						end else if (action == ACT_FLUSH) begin
							state_q <= S_FLUSH;
						end
					end
				end
				S_DIV: begin
					rem_q     <= take ? diff[4:0] : trial[4:0];
					quo_q     <= {quo_q[4:0], take};
					dvd_q     <= {dvd_q[4:0], 1'b0};
					div_cnt_q <= div_cnt_q + 3'd1;
					if (div_cnt_q == 3'd5) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					rd_ok_q  <= ({1'b0, off_q} < bpg_eff) && (32'(off_q) < MAX_GLYPH_BYTES) &&
						(32'(code_q) < GLYPH_COUNT);
					mod_ok_q <= (quo_q != 6'd0) && (grp_q < {1'b0, h_eff});
					par_q    <= grp_q[0];
					off_q    <= off_q + 6'd1;
					if (quo_q != 6'd0) begin
						if (6'(grem_q + 6'd1) == quo_q) begin
							grem_q <= '0;
							grp_q  <= grp_q + 6'd1;
						end else begin
							grem_q <= grem_q + 6'd1;
						end
					end
					state_q <= S_CAPTURE;
				end
				S_CAPTURE: begin
					if (!byte_sel_q) begin
						byte_hi_q <= mod_byte;
					end else begin
						byte_lo_q <= mod_byte;
					end
					if (two_bytes && !byte_sel_q) begin
						byte_sel_q <= 1'b1;
						state_q    <= S_FETCH;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (slot_free) begin
						pixel_row_q <= pack_row({byte_hi_q, byte_lo_q}, w_eff, fg_q, bg_q);
						pixel_x_q   <= x0[9:0];
						pixel_y_q   <= 10'(y0 + {7'd0, row_q});
						last_q      <= row_last;
						rect_x_q    <= '0;
						rect_y_q    <= '0;
						rect_w_q    <= '0;
						rect_h_q    <= '0;
						row_q       <= row_q + 4'd1;
						byte_sel_q  <= 1'b0;
						state_q     <= row_last ? S_MERGE : S_FETCH;
					end
				end
				S_MERGE: begin
					if ((dirty_w_q | dirty_h_q) != 10'd0) begin
						dirty_x_q <= x1[9:0];
						dirty_y_q <= y1[9:0];
						dirty_w_q <= (wd > 12'(RECT_MAX)) ? RECT_MAX : wd[9:0];
						dirty_h_q <= (hd > 12'(RECT_MAX)) ? RECT_MAX : hd[9:0];
					end else begin
						dirty_x_q <= x0[9:0];
						dirty_y_q <= y0[9:0];
						dirty_w_q <= {5'd0, w_eff};
						dirty_h_q <= {5'd0, h_eff};
					end
					state_q <= S_IDLE;
				end
				S_FLUSH: begin
					if (slot_free) begin
						pixel_row_q <= '0;
						pixel_x_q   <= '0;
						pixel_y_q   <= '0;
						last_q      <= 1'b1;
						rect_x_q    <= dirty_x_q;
						rect_y_q    <= dirty_y_q;
						rect_w_q    <= dirty_w_q;
						rect_h_q    <= dirty_h_q;
						dirty_w_q   <= '0;
						dirty_h_q   <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_row = pixel_row_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign last      = last_q;
	assign rect_x    = rect_x_q;
	assign rect_y    = rect_y_q;
	assign rect_w    = rect_w_q;
	assign rect_h    = rect_h_q;

endmodule

`default_nettype wire

FILE: rtl/grdr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module grdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/grdr_checker.sv
// Port-level checks for the glyph renderer, bound to the top level.
// Depends on nothing but the top level's ports.
`default_nettype none

module grdr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] pixel_row,
	input wire logic [9:0]  pixel_x,
	input wire logic [9:0]  pixel_y,
	input wire logic        last,
	input wire logic [9:0]  rect_x,
	input wire logic [9:0]  rect_y,
	input wire logic [9:0]  rect_w,
	input wire logic [9:0]  rect_h
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_row) && $stable(pixel_y) &&
			$stable(last) && $stable(rect_w))
		else $error("stalled result changed");

	a_rect_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((rect_w == 10'd0) == (rect_h == 10'd0)))
		else $error("dirty rectangle half empty");

	a_row_no_rect: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> rect_x == 10'd0 && rect_y == 10'd0 &&
			rect_w == 10'd0 && rect_h == 10'd0)
		else $error("inner glyph row carries rectangle");

	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rect_w != 10'd0 |-> last && pixel_row == 64'd0 &&
			pixel_x == 10'd0 && pixel_y == 10'd0)
		else $error("flush result carries pixels");

endmodule

bind glyph_renderer_with_dirty_rect_top grdr_checker u_grdr_checker (.*);

`default_nettype wire

FILE: test/grdr_render_checker.sv
`timescale 1ns / 1ps
// Checker for glyph_renderer_with_dirty_rect_top: tracks register writes and input
// transfers, predicts every glyph row and flush rectangle, and compares them in order
// with the output transfers. Depends on grdr_pkg.

module grdr_render_checker
	import grdr_pkg::*;
#(
	parameter int GLYPH_N     = 128,
	parameter int GLYPH_BYTES = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic [1:0]            action,
	input  wire logic [6:0]            char_code,
	input  wire logic [4:0]            byte_index,
	input  wire logic [7:0]            font_byte,
	input  wire logic [5:0]            text_col,
	input  wire logic [5:0]            text_row,
	input  wire logic [7:0]            colour,
	input  wire logic                  invert,
	input  wire logic                  shade,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire logic [63:0]           pixel_row,
	input  wire logic [9:0]            pixel_x,
	input  wire logic [9:0]            pixel_y,
	input  wire logic                  last,
	input  wire logic [9:0]            rect_x,
	input  wire logic [9:0]            rect_y,
	input  wire logic [9:0]            rect_w,
	input  wire logic [9:0]            rect_h,
	output int                         err_count,
	output int                         pending,
	output int                         results_seen
);

	typedef struct packed {
		logic [63:0] pixel_row;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic        last;
		logic [9:0]  rect_x;
		logic [9:0]  rect_y;
		logic [9:0]  rect_w;
		logic [9:0]  rect_h;
	} render_out_t;

	render_out_t expected_rows[$];
	render_out_t oldest;
	render_out_t flush_res;

	logic [7:0] font_copy [0:GLYPH_N*GLYPH_BYTES-1];
	int unsigned dirty_x0, dirty_y0, dirty_wd, dirty_ht;
	logic [4:0] width_reg, height_reg;
	logic [5:0] bpg_reg;
	logic       mode_reg;
	int         errors, seen;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	task automatic widen_dirty(input int unsigned x, input int unsigned y,
			input int unsigned w, input int unsigned h);
		int unsigned x1, y1, x2, y2;
		if ((dirty_wd | dirty_ht) != 0) begin
			x1 = (x < dirty_x0) ? x : dirty_x0;
			y1 = (y < dirty_y0) ? y : dirty_y0;
			x2 = (x + w > dirty_x0 + dirty_wd) ? x + w : dirty_x0 + dirty_wd;
			y2 = (y + h > dirty_y0 + dirty_ht) ? y + h : dirty_y0 + dirty_ht;
			dirty_x0 = x1;
			dirty_y0 = y1;
			dirty_wd = (x2 - x1 > RECT_MAX) ? RECT_MAX : x2 - x1;
			dirty_ht = (y2 - y1 > RECT_MAX) ? RECT_MAX : y2 - y1;
		end else begin
			dirty_x0 = x & RECT_MAX;
			dirty_y0 = y & RECT_MAX;
			dirty_wd = (w > RECT_MAX) ? RECT_MAX : w;
			dirty_ht = (h > RECT_MAX) ? RECT_MAX : h;
		end
	endtask

	task automatic render_cell(input logic [6:0] code, input logic [5:0] col,
			input logic [5:0] row, input logic [7:0] attr, input logic inv, input logic shd);
		int unsigned w, h, bpg, line, modified, x0, y0, offset, k, r, i;
		logic [7:0]  xmask, b, cur, bitm;
		logic [63:0] fg, bg, pix;
		render_out_t res;
		w = clamp_dim(width_reg, MAX_GLYPH_DIM);
		h = clamp_dim(height_reg, MAX_GLYPH_DIM);
		bpg = clamp_dim(bpg_reg, GLYPH_BYTES);
		line = bpg / h;
		modified = h * line;
		xmask = (inv || (attr[7] && !mode_reg)) ? INV_MASK : 8'h00;
		fg = {60'd0, attr[3:0]};
		bg = {61'd0, attr[6:4]};
		x0 = w * col;
		y0 = h * row;
		offset = 0;
		cur = 8'h00;
		for (r = 0; r < h; r++) begin
			pix = 64'd0;
			bitm = 8'h00;
			for (i = 0; i < w; i++) begin
				if (bitm == 0) begin
					k = offset;
					offset++;
					b = 8'h00;
					if (k < bpg && k < GLYPH_BYTES && code < GLYPH_N)
						b = font_copy[code * GLYPH_BYTES + k];
					if (k < modified) begin
						b = b ^ xmask;
						if (shd)
							b = b | (((k / line) % 2) ? SHADE_ODD : SHADE_EVEN);
					end
					cur = b;
					bitm = 8'h80;
				end
				pix = pix | ((((cur & bitm) != 0) ? fg : bg) << (60 - 4 * i));
				bitm = bitm >> 1;
			end
			res = '0;
			res.pixel_row = pix;
			res.pixel_x = x0[9:0];
			res.pixel_y = 10'(y0 + r);
			res.last = (r + 1 == h);
			expected_rows.push_back(res);
		end
		widen_dirty(x0, y0, w, h);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < GLYPH_N * GLYPH_BYTES; a++)
				font_copy[a] = 8'h00;
			dirty_x0 = 0;
			dirty_y0 = 0;
			dirty_wd = 0;
			dirty_ht = 0;
			width_reg = RST_GLYPH_WIDTH;
			height_reg = RST_GLYPH_HEIGHT;
			bpg_reg = RST_BYTES_PER_GLYPH;
			mode_reg = RST_TEXT_MODE;
			expected_rows.delete();
			errors = 0;
			seen = 0;
			err_count <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GLYPH_WIDTH:     width_reg = cfg_data[4:0];
					REG_GLYPH_HEIGHT:    height_reg = cfg_data[4:0];
					REG_BYTES_PER_GLYPH: bpg_reg = cfg_data[5:0];
					REG_TEXT_MODE:       mode_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				seen++;
				if (expected_rows.size() == 0) begin
					report_mismatch($sformatf("unexpected result transfer, pixel_row 0x%0h",
						pixel_row));
				end else begin
					oldest = expected_rows.pop_front();
					check_field("pixel_row", pixel_row, oldest.pixel_row);
					check_field("pixel_x", pixel_x, oldest.pixel_x);
					check_field("pixel_y", pixel_y, oldest.pixel_y);
					check_field("last", last, oldest.last);
					check_field("rect_x", rect_x, oldest.rect_x);
					check_field("rect_y", rect_y, oldest.rect_y);
					check_field("rect_w", rect_w, oldest.rect_w);
					check_field("rect_h", rect_h, oldest.rect_h);
				end
			end
			if (in_valid && !in_stall) begin
				case (action)
					ACT_LOAD: begin
						if (char_code < GLYPH_N && byte_index < GLYPH_BYTES)
							font_copy[char_code * GLYPH_BYTES + byte_index] = font_byte;
					end
					ACT_PUT: render_cell(char_code, text_col, text_row, colour, invert, shade);
					ACT_FLUSH: begin
						flush_res = '0;
						flush_res.last = 1'b1;
						flush_res.rect_x = dirty_x0[9:0];
						flush_res.rect_y = dirty_y0[9:0];
						flush_res.rect_w = dirty_wd[9:0];
						flush_res.rect_h = dirty_ht[9:0];
						expected_rows.push_back(flush_res);
						dirty_wd = 0;
						dirty_ht = 0;
					end
					default: ;
				endcase
			end
			err_count <= errors;
			pending <= expected_rows.size();
			results_seen <= seen;
		end
	end

endmodule

FILE: test/glyph_renderer_with_dirty_rect_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for glyph_renderer_with_dirty_rect_top: directed and random font
// loads, character puts and flushes under a series of register settings.
// Depends on grdr_pkg, the block and grdr_render_checker.

module glyph_renderer_with_dirty_rect_top_tb;
	import grdr_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 120;
	localparam int PHASE_ITEMS     = 11;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int NUM_PHASES      = 7;

	localparam action_t ACT_IGNORED = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	typedef struct packed {
		action_t    act;
		logic [6:0] char_code;
		logic [4:0] byte_index;
		logic [7:0] font_byte;
		logic [5:0] text_col;
		logic [5:0] text_row;
		logic [7:0] colour;
		logic       invert;
		logic       shade;
	} cell_cmd_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [1:0]            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [1:0]            action;
	logic [6:0]            char_code;
	logic [4:0]            byte_index;
	logic [7:0]            font_byte;
	logic [5:0]            text_col;
	logic [5:0]            text_row;
	logic [7:0]            colour;
	logic                  invert;
	logic                  shade;
	logic                  out_valid;
	logic                  out_stall;
	logic [63:0]           pixel_row;
	logic [9:0]            pixel_x;
	logic [9:0]            pixel_y;
	logic                  last;
	logic [9:0]            rect_x;
	logic [9:0]            rect_y;
	logic [9:0]            rect_w;
	logic [9:0]            rect_h;
	int                    err_count;
	int                    pending;
	int                    results_seen;

	int          n_items = 0;
	int          n_directed = 0;
	int          burst_left = 4;
	bit          pressure_go = 1'b0;
	bit          pressure_done = 1'b0;
	int unsigned cycles = 0;

	glyph_renderer_with_dirty_rect_top i_dut (.*);

	grdr_render_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		stall_mode_t mode;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			repeat ($urandom_range(20, 120)) begin
				if (pressure_go && !pressure_done) begin
					out_stall <= 1'b1;
					repeat (HOLD_OFF_CYCLES) @(posedge clk);
					pressure_done = 1'b1;
				end else begin
					case (mode)
						STALL_NONE:  out_stall <= 1'b0;
						STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
						STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
						default:     out_stall <= (cycles % 5 < 2);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	function automatic logic [5:0] pick_cell_coord();
		case ($urandom_range(0, 7))
			0: return 6'd0;
			1: return 6'd63;
			default: return 6'($urandom_range(0, 63));
		endcase
	endfunction

	function automatic logic [6:0] pick_code();
		if ($urandom_range(0, 5) == 0)
			return $urandom_range(0, 1) ? 7'd127 : 7'd0;
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic cell_cmd_t random_cmd(input action_t act);
		cell_cmd_t c;
		c.act = act;
		c.char_code = pick_code();
		c.byte_index = 5'($urandom_range(0, 31));
		c.font_byte = 8'($urandom_range(0, 255));
		c.text_col = pick_cell_coord();
		c.text_row = pick_cell_coord();
		c.colour = 8'($urandom_range(0, 255));
		c.invert = 1'($urandom_range(0, 1));
		c.shade = 1'($urandom_range(0, 1));
		return c;
	endfunction

	function automatic cell_cmd_t mk_cmd(input action_t act, input logic [6:0] code,
			input logic [4:0] idx, input logic [7:0] fbyte, input logic [5:0] col,
			input logic [5:0] row, input logic [7:0] attr, input logic inv, input logic shd);
		cell_cmd_t c;
		c.act = act;
		c.char_code = code;
		c.byte_index = idx;
		c.font_byte = fbyte;
		c.text_col = col;
		c.text_row = row;
		c.colour = attr;
		c.invert = inv;
		c.shade = shd;
		return c;
	endfunction

	task automatic send_cmd(input cell_cmd_t c);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
		end
		action <= c.act;
		char_code <= c.char_code;
		byte_index <= c.byte_index;
		font_byte <= c.font_byte;
		text_col <= c.text_col;
		text_row <= c.text_row;
		colour <= c.colour;
		invert <= c.invert;
		shade <= c.shade;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		burst_left--;
		n_items++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [4:0] w, input logic [4:0] h,
			input logic [5:0] bpg, input logic tm);
		cfg_we <= 1'b1;
		cfg_index <= REG_GLYPH_WIDTH;
		cfg_data <= {1'b0, w};
		@(posedge clk);
		cfg_index <= REG_GLYPH_HEIGHT;
		cfg_data <= {1'b0, h};
		@(posedge clk);
		cfg_index <= REG_BYTES_PER_GLYPH;
		cfg_data <= bpg;
		@(posedge clk);
		cfg_index <= REG_TEXT_MODE;
		cfg_data <= {5'd0, tm};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random_phase();
		int count, n, sel;
		logic [6:0] code;
		cell_cmd_t c;
		c = random_cmd(ACT_PUT);
		c.text_col = 6'd0;
		c.text_row = 6'd0;
		send_cmd(c);
		c = random_cmd(ACT_PUT);
		c.text_col = 6'd63;
		c.text_row = 6'd63;
		send_cmd(c);
		count = 2;
		while (count < PHASE_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				code = pick_code();
				n = $urandom_range(1, 4);
				repeat (n) begin
					c = random_cmd(ACT_LOAD);
					c.char_code = code;
					if ($urandom_range(0, 3) != 0)
						c.byte_index = 5'($urandom_range(0, 15));
					send_cmd(c);
				end
				c = random_cmd(ACT_PUT);
				c.char_code = code;
				send_cmd(c);
				count += n + 1;
			end else if (sel < 75) begin
				send_cmd(random_cmd(ACT_PUT));
				count++;
			end else if (sel < 88) begin
				send_cmd(random_cmd(ACT_FLUSH));
				count++;
			end else begin
				c = random_cmd(action_t'($urandom_range(0, 3)));
				send_cmd(c);
				if (c.act != ACT_IGNORED)
					count++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_GLYPH_WIDTH;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= ACT_LOAD;
		char_code <= '0;
		byte_index <= '0;
		font_byte <= '0;
		text_col <= '0;
		text_row <= '0;
		colour <= '0;
		invert <= 1'b0;
		shade <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// default geometry: 8x8 cells, 8 bytes per glyph, graphics mode
		send_cmd(mk_cmd(ACT_FLUSH, 7'd0, 5'd0, 8'h00, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_LOAD, 7'd65, 5'd0, 8'hFF, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_LOAD, 7'd65, 5'd1, 8'h81, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_LOAD, 7'd65, 5'd7, 8'h3C, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_LOAD, 7'd65, 5'd31, 8'hFF, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_LOAD, 7'd127, 5'd2, 8'hA5, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_PUT, 7'd65, 5'd0, 8'h00, 6'd0, 6'd0, 8'h0F, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_PUT, 7'd65, 5'd31, 8'hFF, 6'd63, 6'd63, 8'hFF, 1'b0, 1'b1));
		send_cmd(mk_cmd(ACT_PUT, 7'd65, 5'd0, 8'h00, 6'd5, 6'd9, 8'h70, 1'b1, 1'b0));
		send_cmd(mk_cmd(ACT_PUT, 7'd127, 5'd0, 8'h00, 6'd63, 6'd0, 8'h80, 1'b1, 1'b0));
		send_cmd(mk_cmd(ACT_PUT, 7'd0, 5'd0, 8'h00, 6'd0, 6'd63, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_FLUSH, 7'd127, 5'd31, 8'hFF, 6'd63, 6'd63, 8'hFF, 1'b1, 1'b1));
		send_cmd(mk_cmd(ACT_FLUSH, 7'd0, 5'd0, 8'h00, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_IGNORED, 7'd65, 5'd3, 8'h5A, 6'd7, 6'd7, 8'hC3, 1'b1, 1'b1));
		send_cmd(mk_cmd(ACT_PUT, 7'd65, 5'd0, 8'h00, 6'd1, 6'd1, 8'h5A, 1'b0, 1'b1));
		send_cmd(mk_cmd(ACT_LOAD, 7'd127, 5'd31, 8'h00, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		send_cmd(mk_cmd(ACT_PUT, 7'd127, 5'd0, 8'h00, 6'd2, 6'd3, 8'h2B, 1'b0, 1'b1));
		send_cmd(mk_cmd(ACT_FLUSH, 7'd0, 5'd0, 8'h00, 6'd0, 6'd0, 8'h00, 1'b0, 1'b0));
		n_directed = n_items;
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: write_settings(5'd16, 5'd16, 6'd32, 1'b1);
				1: write_settings(5'd1, 5'd1, 6'd1, 1'b0);
				2: write_settings(5'd0, 5'd0, 6'd0, 1'b1);
				3: write_settings(5'd31, 5'd31, 6'd63, 1'b0);
				4: write_settings(5'd12, 5'd5, 6'd17, 1'b0);
				5: write_settings(5'd8, 5'd16, 6'd4, 1'b1);
				default: write_settings(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
			endcase
			if (p == 0)
				pressure_go = 1'b1;
			run_random_phase();
			drain_results();
		end

		$display("Coverage: %0d input transfers (%0d directed), %0d output transfers checked",
			n_items, n_directed, results_seen);
		$display("Coverage: %0d register settings incl. saturated extremes, %0d-cycle hold-off",
			NUM_PHASES + 1, HOLD_OFF_CYCLES);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: files.f
rtl/grdr_pkg.sv
rtl/grdr_ram.sv
rtl/glyph_renderer_with_dirty_rect_top.sv
rtl/grdr_checker.sv
test/grdr_render_checker.sv
test/glyph_renderer_with_dirty_rect_top_tb.sv
